// ===== sv/kvm_pkg.sv =====
// ---------------------------------------------------------------------------
// kvm_pkg: shared constants for the KV-cache attention mask generator
// Field widths, storage geometry and the operation and register codes.
// ---------------------------------------------------------------------------
package kvm_pkg;

  localparam int KV_DEPTH    = 1024;
  localparam int CHUNK_BITS  = 32;
  localparam int SEQ_SLOTS   = 16;
  localparam int POS_BITS    = 24;

  localparam int ROWS        = KV_DEPTH / CHUNK_BITS;
  localparam int ROW_W       = $clog2(ROWS);
  localparam int LANE_W      = $clog2(CHUNK_BITS);

  localparam int IDX_W       = 10;
  localparam int OWN_W       = SEQ_SLOTS;
  localparam int SEQ_W       = 4;
  localparam int LEN_W       = 11;
  localparam int CHUNK_NUM_W = 5;

  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 11;

  localparam logic [CFG_IDX_W-1:0] REG_CAUSAL_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KV_LENGTH   = 1'd1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

// ===== sv/kvm_channels.sv =====
// ---------------------------------------------------------------------------
// kvm_channels: valid/ready channels of the mask generator
// The request channel carries write and query beats; the mask channel
// carries one chunk of a mask row per beat.
// ---------------------------------------------------------------------------
interface kvm_req_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [kvm_pkg::IDX_W-1:0]     cell_index;
  logic                          cell_free;
  logic [kvm_pkg::POS_BITS-1:0]  cell_position;
  logic [kvm_pkg::OWN_W-1:0]     cell_owner_set;
  logic [kvm_pkg::SEQ_W-1:0]     query_sequence;
  logic [kvm_pkg::POS_BITS-1:0]  query_position;

  modport source (output valid, operation, cell_index, cell_free, cell_position,
                  cell_owner_set, query_sequence, query_position, input ready);
  modport sink   (input valid, operation, cell_index, cell_free, cell_position,
                  cell_owner_set, query_sequence, query_position, output ready);
endinterface

interface kvm_mask_if;
  logic                             valid;
  logic                             ready;
  logic [kvm_pkg::CHUNK_BITS-1:0]   mask_bits;
  logic [kvm_pkg::CHUNK_NUM_W-1:0]  chunk_number;
  logic                             last_chunk;

  modport source (output valid, mask_bits, chunk_number, last_chunk, input ready);
  modport sink   (input valid, mask_bits, chunk_number, last_chunk, output ready);
endinterface

// ===== sv/kv_attention_mask_generator_core.sv =====
// ---------------------------------------------------------------------------
// kv_attention_mask_generator_core: KV-cache attention mask row generator
// Stores one descriptor per cache cell and builds mask rows chunk by chunk.
// ---------------------------------------------------------------------------
// Usage:
// The request channel (in_ch) takes two kinds of beat. A write beat loads the
// free flag, position and owner set of one cell and gives no output. A query
// beat builds one mask row over the first kv_length cells (saturated at the
// cache depth) and sends it on the mask channel (out_ch) as ceil(len/32)
// beats of 32 bits, chunk_number counting up, last_chunk set on the final
// one. A query with kv_length zero gives no beat.
// The descriptor store is organized as rows of 32 cells. One shared 32-lane
// evaluator (ownership, free flag, causal compare) processes one row per
// cycle under a small sequencer while the receiver keeps up; each row goes
// through the registered read stage and then into the output register.
// in_ch.ready is low while a query runs and rises again once its last chunk
// sits in the output register. If the receiver stalls, the output register
// holds its beat and the read stage and sequencer hold too; nothing is
// dropped. Reset sets causal_mode to 1, kv_length to 0 and marks every cell
// free through per-row valid bits. The user must write configuration through
// cfg_we/cfg_index/cfg_data only while idle; the block has no such guard.
// ---------------------------------------------------------------------------
module kv_attention_mask_generator_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [kvm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kvm_pkg::CFG_DATA_W-1:0]  cfg_data,
  kvm_req_if.sink                         in_ch,
  kvm_mask_if.source                      out_ch
);
  import kvm_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  // Configuration registers.
  logic             causal_mode;
  logic [LEN_W-1:0] kv_length;

  // Descriptor store, one row per chunk of cells.
  logic [CHUNK_BITS-1:0]               free_mem [ROWS];
  logic [CHUNK_BITS-1:0][POS_BITS-1:0] pos_mem  [ROWS];
  logic [CHUNK_BITS-1:0][OWN_W-1:0]    own_mem  [ROWS];
  logic [ROWS-1:0]                     row_valid;

  // Sequencer and query context.
  logic                   state;
  logic [SEQ_W-1:0]       q_seq;
  logic [POS_BITS-1:0]    q_pos;
  logic [LEN_W-1:0]       q_len;
  logic [CHUNK_NUM_W-1:0] q_last;
  logic [ROW_W-1:0]       issue_row;
  logic                   issue_done;

  // Read stage.
  logic                                rd_valid;
  logic [CHUNK_NUM_W-1:0]              rd_chunk;
  logic                                rd_row_valid;
  logic [CHUNK_BITS-1:0]               rd_free;
  logic [CHUNK_BITS-1:0][POS_BITS-1:0] rd_pos;
  logic [CHUNK_BITS-1:0][OWN_W-1:0]    rd_own;

  // Output register.
  logic                   out_valid;
  logic [CHUNK_BITS-1:0]  out_bits;
  logic [CHUNK_NUM_W-1:0] out_chunk;
  logic                   out_last;

  logic                  in_fire, wr_en, q_start;
  logic [ROW_W-1:0]      wr_row;
  logic [LANE_W-1:0]     wr_lane;
  logic [CHUNK_BITS-1:0] free_fill;
  logic [LEN_W-1:0]      sat_len;
  logic [LEN_W-1:0]      sat_len_m1;
  logic                  out_free, issue, load, load_last;
  logic [CHUNK_BITS-1:0] cell_free_eff;
  logic [CHUNK_BITS-1:0] attend;

  assign in_ch.ready = (state == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign wr_en       = in_fire && (in_ch.operation == OP_WRITE);
  assign wr_row      = in_ch.cell_index[LANE_W +: ROW_W];
  assign wr_lane     = in_ch.cell_index[LANE_W-1:0];

  assign sat_len    = (kv_length > LEN_W'(KV_DEPTH)) ? LEN_W'(KV_DEPTH) : kv_length;
  assign sat_len_m1 = sat_len - LEN_W'(1);
  assign q_start    = in_fire && (in_ch.operation == OP_QUERY) && (sat_len != '0);

  // The first write into a row fills the other cells of that row as free.
  always_comb begin
    free_fill          = '1;
    free_fill[wr_lane] = in_ch.cell_free;
  end

  assign out_free  = !out_valid || out_ch.ready;
  assign issue     = (state == ST_RUN) && !issue_done && (!rd_valid || out_free);
  assign load      = rd_valid && out_free;
  assign load_last = load && (rd_chunk == q_last);

  // Shared 32-lane evaluator over the row held in the read stage.
  assign cell_free_eff = rd_row_valid ? rd_free : '1;

  always_comb begin
    for (int i = 0; i < CHUNK_BITS; i++) begin
      attend[i] = !cell_free_eff[i] && rd_own[i][q_seq]
                  && !(causal_mode && (rd_pos[i] > q_pos))
                  && ((rd_chunk != q_last) || (q_len[LANE_W-1:0] == '0)
                      || (LANE_W'(i) < q_len[LANE_W-1:0]));
    end
  end

  // Configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      causal_mode <= 1'b1;
      kv_length   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAUSAL_MODE: causal_mode <= cfg_data[0];
        REG_KV_LENGTH:   kv_length   <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Descriptor store: write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (row_valid[wr_row]) begin
        free_mem[wr_row][wr_lane] <= in_ch.cell_free;
      end else begin
        free_mem[wr_row] <= free_fill;
      end
      pos_mem[wr_row][wr_lane] <= in_ch.cell_position;
      own_mem[wr_row][wr_lane] <= in_ch.cell_owner_set;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_row] <= 1'b1;
    end
  end

  // Descriptor store: registered read port.
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_free      <= free_mem[issue_row];
      rd_pos       <= pos_mem[issue_row];
      rd_own       <= own_mem[issue_row];
      rd_row_valid <= row_valid[issue_row];
      rd_chunk     <= CHUNK_NUM_W'(issue_row);
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      issue_done <= 1'b0;
      rd_valid   <= 1'b0;
    end else begin
      if (q_start) begin
        state      <= ST_RUN;
        issue_done <= 1'b0;
      end else if (load_last) begin
        state <= ST_IDLE;
      end
      if (issue && (CHUNK_NUM_W'(issue_row) == q_last)) begin
        issue_done <= 1'b1;
      end
      if (issue) begin
        rd_valid <= 1'b1;
      end else if (out_free) begin
        rd_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_start) begin
      q_seq     <= in_ch.query_sequence;
      q_pos     <= in_ch.query_position;
      q_len     <= sat_len;
      q_last    <= sat_len_m1[LANE_W +: CHUNK_NUM_W];
      issue_row <= '0;
    end else if (issue) begin
      issue_row <= issue_row + ROW_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_bits  <= attend;
      out_chunk <= rd_chunk;
      out_last  <= (rd_chunk == q_last);
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.mask_bits    = out_bits;
  assign out_ch.chunk_number = out_chunk;
  assign out_ch.last_chunk   = out_last;

  // A chunk that is not the last one leaves while its query still runs.
  a_mid_chunk_running: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && !out_ch.last_chunk) |-> (state == ST_RUN))
    else $error("non-final chunk delivered with the sequencer idle");

  // The read stage only holds a row on behalf of a running query.
  a_read_in_run: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> (state == ST_RUN))
    else $error("read stage valid outside a query");

  // A running query always covers at least one cell and no more than the cache.
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> ((q_len != '0) && (q_len <= LEN_W'(KV_DEPTH))))
    else $error("query length out of range while running");

endmodule

// ===== tb/kv_attention_mask_generator_core_tb.sv =====
// ---------------------------------------------------------------------------
// kv_attention_mask_generator_core_tb: self-checking bench for the mask core
// Walks a directed table of writes, queries and register settings, then
// runs random phases over several register settings. Every mask beat is
// checked against an in-bench row builder or a typed table expectation.
// ---------------------------------------------------------------------------
module kv_attention_mask_generator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kvm_pkg::*;

  // Cycles without any accepted beat before the run is declared hung. The
  // slowest correct gap is a long sender gap plus a long receiver stall plus
  // the register settle time.
  localparam int STALL_LIMIT = 3000;
  // Cycles waited after the last mask beat before a register write, so a
  // trailing write beat has surely landed in the descriptor store.
  localparam int SETTLE_CYCLES = 8;
  // Cycles waited at the end for stray beats.
  localparam int TAIL_CYCLES = 20;

  typedef enum logic {STEP_CFG, STEP_BEAT} step_kind_t;

  // One line of stimulus: either a register write or a request beat.
  typedef struct {
    step_kind_t              kind;
    logic [CFG_IDX_W-1:0]    reg_sel;
    logic [CFG_DATA_W-1:0]   reg_val;
    logic                    op;
    logic [IDX_W-1:0]        idx;
    logic                    free;
    logic [POS_BITS-1:0]     pos;
    logic [OWN_W-1:0]        own;
    logic [SEQ_W-1:0]        seq;
    logic [POS_BITS-1:0]     qpos;
    bit                      typed;
    logic [CHUNK_BITS-1:0]   typed_bits;
  } step_t;

  // One chunk of a mask row as it should leave the block.
  typedef struct {
    logic [CHUNK_BITS-1:0]   bits;
    logic [CHUNK_NUM_W-1:0]  num;
    logic                    last;
  } mask_chunk_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  kvm_req_if  req_bus();
  kvm_mask_if mask_bus();

  kv_attention_mask_generator_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (req_bus),
    .out_ch    (mask_bus)
  );

  // Shadow copy of the descriptor store and the two registers.
  logic                 cell_free_tab [KV_DEPTH];
  logic [POS_BITS-1:0]  cell_pos_tab  [KV_DEPTH];
  logic [OWN_W-1:0]     cell_own_tab  [KV_DEPTH];
  logic                 causal_on;
  logic [LEN_W-1:0]     kv_len;

  // Mask chunks predicted but not yet seen, oldest first.
  mask_chunk_t mask_chunks_due[$];

  step_t dir_steps[$];
  step_t cur_step;
  int    errs;
  int    idle_cycles;
  bit    calm;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Gap lengths: about half are zero, most of the rest short, a few long.
  // In a calm phase there is no idling at all.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic step_t cfg_step(logic [CFG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] val);
    step_t s;
    s = '{kind: STEP_CFG, default: '0};
    s.kind    = STEP_CFG;
    s.reg_sel = sel;
    s.reg_val = val;
    return s;
  endfunction

  // Query fields on a write beat carry random junk; the block must ignore it.
  function automatic step_t wr_step(logic [IDX_W-1:0] idx, logic free,
                                    logic [POS_BITS-1:0] pos, logic [OWN_W-1:0] own);
    step_t s;
    s = '{kind: STEP_BEAT, default: '0};
    s.kind = STEP_BEAT;
    s.op   = OP_WRITE;
    s.idx  = idx;
    s.free = free;
    s.pos  = pos;
    s.own  = own;
    s.seq  = SEQ_W'($urandom);
    s.qpos = POS_BITS'($urandom);
    return s;
  endfunction

  // Write fields on a query beat carry random junk as well.
  function automatic step_t q_step(logic [SEQ_W-1:0] seq, logic [POS_BITS-1:0] qpos,
                                   bit typed, logic [CHUNK_BITS-1:0] typed_bits);
    step_t s;
    s = '{kind: STEP_BEAT, default: '0};
    s.kind       = STEP_BEAT;
    s.op         = OP_QUERY;
    s.idx        = IDX_W'($urandom);
    s.free       = 1'($urandom);
    s.pos        = POS_BITS'($urandom);
    s.own        = OWN_W'($urandom);
    s.seq        = seq;
    s.qpos       = qpos;
    s.typed      = typed;
    s.typed_bits = typed_bits;
    return s;
  endfunction

  // Builds the expected chunks of one mask row from the shadow store. A cell
  // is attended when it is occupied, owned by the query sequence and, with
  // causal masking on, not positioned after the query. The row length
  // saturates at the cache depth, and the tail of a partial chunk is zero.
  function automatic void build_mask_row(logic [SEQ_W-1:0] seq, logic [POS_BITS-1:0] qpos);
    int span;
    int n_chunks;
    int slot;
    mask_chunk_t c;
    span = (kv_len > KV_DEPTH) ? KV_DEPTH : int'(kv_len);
    n_chunks = (span + CHUNK_BITS - 1) / CHUNK_BITS;
    for (int k = 0; k < n_chunks; k++) begin
      c.bits = '0;
      for (int b = 0; b < CHUNK_BITS; b++) begin
        slot = k * CHUNK_BITS + b;
        if (slot < span && !cell_free_tab[slot] && cell_own_tab[slot][seq] &&
            (!causal_on || cell_pos_tab[slot] <= qpos)) begin
          c.bits[b] = 1'b1;
        end
      end
      c.num  = CHUNK_NUM_W'(k);
      c.last = (k == n_chunks - 1);
      mask_chunks_due.push_back(c);
    end
  endfunction

  // Presents one request beat at the falling edge, after a random gap, and
  // returns at the falling edge after the beat has been taken.
  task automatic put_beat(input step_t s);
    int g;
    g = pick_gap();
    if (g > 0) begin
      req_bus.valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    cur_step               = s;
    req_bus.operation      = s.op;
    req_bus.cell_index     = s.idx;
    req_bus.cell_free      = s.free;
    req_bus.cell_position  = s.pos;
    req_bus.cell_owner_set = s.own;
    req_bus.query_sequence = s.seq;
    req_bus.query_position = s.qpos;
    req_bus.valid          = 1'b1;
    @(posedge clk);
    while (req_bus.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
  endtask

  // Register writes happen only with the block idle: the request side is
  // quiet, every predicted chunk has come out, and a trailing write beat has
  // had time to settle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_DATA_W-1:0] val);
    req_bus.valid = 1'b0;
    while (mask_chunks_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = sel;
    cfg_data  = val;
    if (sel == REG_CAUSAL_MODE) causal_on = val[0];
    else kv_len = val[LEN_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // One random phase under a given register setting. Most write beats land
  // inside the covered row and use positions and owners near those of the
  // queries, so that attended, non-owned and causally masked cells all show
  // up; the rest are spread over the whole field range.
  task automatic run_phase(input bit causal, input int len, input int count, input bit quiet);
    int                     span;
    int                     r;
    logic [CFG_DATA_W-1:0]  v;
    logic [POS_BITS-1:0]    base;
    logic [SEQ_W-1:0]       seq_a;
    logic [SEQ_W-1:0]       seq_b;
    logic [IDX_W-1:0]       idx;
    logic [POS_BITS-1:0]    p;
    logic [OWN_W-1:0]       o;
    logic [SEQ_W-1:0]       sq;
    step_t                  s;
    calm = quiet;
    // Upper data bits of the causal register are junk that must be dropped.
    v    = CFG_DATA_W'($urandom);
    v[0] = causal;
    write_reg(REG_CAUSAL_MODE, v);
    write_reg(REG_KV_LENGTH, CFG_DATA_W'(len));
    span  = (len == 0 || len > KV_DEPTH) ? KV_DEPTH : len;
    base  = POS_BITS'($urandom);
    seq_a = SEQ_W'($urandom);
    seq_b = SEQ_W'($urandom);
    repeat (count) begin
      if ($urandom_range(0, 99) < 60) begin
        if ($urandom_range(0, 4) == 0) idx = IDX_W'($urandom);
        else idx = IDX_W'($urandom_range(0, span - 1));
        if ($urandom_range(0, 3) == 0) p = POS_BITS'($urandom);
        else p = base + POS_BITS'($urandom_range(0, 63));
        r = $urandom_range(0, 9);
        if (r < 5) o = OWN_W'($urandom);
        else if (r < 8) o = OWN_W'(1) << ($urandom_range(0, 1) ? seq_a : seq_b);
        else o = '1;
        s = wr_step(idx, ($urandom_range(0, 3) == 0), p, o);
      end else begin
        if ($urandom_range(0, 9) < 7) sq = $urandom_range(0, 1) ? seq_a : seq_b;
        else sq = SEQ_W'($urandom);
        r = $urandom_range(0, 9);
        if (r < 6) p = base + POS_BITS'($urandom_range(0, 63));
        else if (r < 8) p = POS_BITS'($urandom);
        else if (r == 8) p = '0;
        else p = '1;
        s = q_step(sq, p, 1'b0, '0);
      end
      put_beat(s);
    end
  endtask

  // Receiver: ready drops for random stretches and stays up for bursts.
  initial begin
    int g;
    mask_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      g = pick_gap();
      if (g > 0) begin
        mask_bus.ready = 1'b0;
        repeat (g) @(negedge clk);
      end
      mask_bus.ready = 1'b1;
      repeat ($urandom_range(0, 11)) @(negedge clk);
    end
  end

  // Scoreboard. Request beats are turned into predictions at the edge that
  // accepts them; mask beats are compared with the oldest prediction. Rows
  // with a typed expectation use it in place of the built row.
  always @(posedge clk) begin
    mask_chunk_t want;
    mask_chunk_t t;
    if (!rst) begin
      if (req_bus.valid && req_bus.ready) begin
        if (req_bus.operation == OP_WRITE) begin
          cell_free_tab[req_bus.cell_index] <= req_bus.cell_free;
          cell_pos_tab[req_bus.cell_index]  <= req_bus.cell_position;
          cell_own_tab[req_bus.cell_index]  <= req_bus.cell_owner_set;
        end else if (cur_step.typed) begin
          t.bits = cur_step.typed_bits;
          t.num  = '0;
          t.last = 1'b1;
          mask_chunks_due.push_back(t);
        end else begin
          build_mask_row(req_bus.query_sequence, req_bus.query_position);
        end
      end
      if (mask_bus.valid && mask_bus.ready) begin
        if (mask_chunks_due.size() == 0) begin
          $error("mask beat with nothing expected: mask_bits %h chunk_number %0d",
                 mask_bus.mask_bits, mask_bus.chunk_number);
          errs++;
        end else begin
          want = mask_chunks_due.pop_front();
          if (mask_bus.mask_bits !== want.bits) begin
            $error("mask_bits: expected %h, got %h", want.bits, mask_bus.mask_bits);
            errs++;
          end
          if (mask_bus.chunk_number !== want.num) begin
            $error("chunk_number: expected %0d, got %0d", want.num, mask_bus.chunk_number);
            errs++;
          end
          if (mask_bus.last_chunk !== want.last) begin
            $error("last_chunk: expected %b, got %b", want.last, mask_bus.last_chunk);
            errs++;
          end
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (rst || (req_bus.valid && req_bus.ready) || (mask_bus.valid && mask_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("kv_attention_mask_generator_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst                    = 1'b1;
    cfg_we                 = 1'b0;
    cfg_index              = '0;
    cfg_data               = '0;
    req_bus.valid          = 1'b0;
    req_bus.operation      = OP_WRITE;
    req_bus.cell_index     = '0;
    req_bus.cell_free      = 1'b0;
    req_bus.cell_position  = '0;
    req_bus.cell_owner_set = '0;
    req_bus.query_sequence = '0;
    req_bus.query_position = '0;
    cur_step               = '{kind: STEP_BEAT, default: '0};
    errs                   = 0;
    idle_cycles            = 0;
    calm                   = 1'b0;
    causal_on              = 1'b1;
    kv_len                 = '0;
    foreach (cell_free_tab[i]) begin
      cell_free_tab[i] = 1'b1;
      cell_pos_tab[i]  = '0;
      cell_own_tab[i]  = '0;
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table. A query at the reset length builds no row; the
    // first rows then run with causal masking still at its reset value.
    dir_steps.push_back(q_step(4'd0, 24'd0, 1'b0, '0));
    dir_steps.push_back(cfg_step(REG_KV_LENGTH, 11'd32));
    dir_steps.push_back(q_step(4'd0, 24'd0, 1'b1, 32'h0000_0000));
    dir_steps.push_back(wr_step(10'd0, 1'b0, 24'd0, 16'h0001));
    dir_steps.push_back(wr_step(10'd31, 1'b0, 24'hFF_FFFF, 16'hFFFF));
    dir_steps.push_back(wr_step(10'd5, 1'b0, 24'd100, 16'h8000));
    dir_steps.push_back(wr_step(10'd6, 1'b1, 24'd0, 16'hFFFF));
    dir_steps.push_back(q_step(4'd0, 24'd0, 1'b1, 32'h0000_0001));
    dir_steps.push_back(q_step(4'd0, 24'hFF_FFFF, 1'b1, 32'h8000_0001));
    dir_steps.push_back(q_step(4'd15, 24'hFF_FFFF, 1'b1, 32'h8000_0020));
    dir_steps.push_back(q_step(4'd15, 24'd99, 1'b1, 32'h0000_0000));
    dir_steps.push_back(q_step(4'd15, 24'd100, 1'b1, 32'h0000_0020));
    // Write with all query fields at their top values.
    dir_steps.push_back(wr_step(10'd2, 1'b0, 24'd7, 16'h0004));
    dir_steps[$].seq  = '1;
    dir_steps[$].qpos = '1;
    // Query whose write fields would light cell 3 if they were not ignored.
    dir_steps.push_back(q_step(4'd2, 24'd7, 1'b1, 32'h0000_0004));
    dir_steps[$].idx  = 10'd3;
    dir_steps[$].free = 1'b0;
    dir_steps[$].pos  = '0;
    dir_steps[$].own  = '1;
    dir_steps.push_back(wr_step(10'd0, 1'b1, 24'd0, 16'h0001));
    // Decode mode: positions no longer matter.
    dir_steps.push_back(cfg_step(REG_CAUSAL_MODE, 11'd0));
    dir_steps.push_back(q_step(4'd15, 24'd0, 1'b1, 32'h8000_0020));
    dir_steps.push_back(q_step(4'd0, 24'd0, 1'b1, 32'h8000_0000));
    dir_steps.push_back(wr_step(10'd1023, 1'b0, 24'd5, 16'h0002));
    // Length beyond the cache depth saturates to a full row.
    dir_steps.push_back(cfg_step(REG_KV_LENGTH, 11'd2047));
    dir_steps.push_back(q_step(4'd1, 24'd0, 1'b0, '0));
    dir_steps.push_back(cfg_step(REG_CAUSAL_MODE, 11'd1));
    dir_steps.push_back(q_step(4'd1, 24'd4, 1'b0, '0));
    // One full chunk plus a single cell in a partial chunk.
    dir_steps.push_back(cfg_step(REG_KV_LENGTH, 11'd33));
    dir_steps.push_back(q_step(4'd15, 24'hFF_FFFF, 1'b0, '0));
    dir_steps.push_back(cfg_step(REG_KV_LENGTH, 11'd1));
    dir_steps.push_back(q_step(4'd0, 24'hFF_FFFF, 1'b1, 32'h0000_0000));

    foreach (dir_steps[i]) begin
      if (dir_steps[i].kind == STEP_CFG) write_reg(dir_steps[i].reg_sel, dir_steps[i].reg_val);
      else put_beat(dir_steps[i]);
    end

    // Random phases, from tiny rows to saturated ones, two without idling.
    run_phase(1'b1, 64, 45, 1'b0);
    run_phase(1'b0, 1024, 40, 1'b0);
    run_phase(1'b1, 1, 35, 1'b1);
    run_phase(1'b1, 0, 20, 1'b0);
    run_phase(1'b0, 95, 45, 1'b0);
    run_phase(1'b1, 2047, 40, 1'b0);
    run_phase(1'b1, 31, 45, 1'b0);
    run_phase(1'b0, 512, 40, 1'b0);
    run_phase(1'b1, $urandom_range(2, 1100), 40, 1'b0);
    run_phase(1'b1, 1024, 30, 1'b1);

    // Drain: every predicted chunk must arrive, then watch for strays.
    req_bus.valid = 1'b0;
    calm = 1'b0;
    while (mask_chunks_due.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errs == 0) begin
      $display("kv_attention_mask_generator_core verification clean");
    end else begin
      $display("kv_attention_mask_generator_core verification failed");
    end
    $finish;
  end

endmodule
